/* hw/rtl/blim_pkg.sv */
// Shared constants, operation codes and controller/datapath types for the item list.
package blim_pkg;

    localparam int DEF_MAX_SLOTS = 8;
    localparam int DEF_ID_BITS   = 16;

    localparam int KEY_W  = 16;
    localparam int OP_W   = 3;
    localparam int CAP_W  = 4;
    localparam int STAT_W = 4;

    localparam logic [CAP_W-1:0]  CAP_RESET = 4'd8;
    localparam logic [STAT_W-1:0] STAT_MAX  = 4'hF;

    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_OLD = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_NEW = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

    typedef struct packed {
        logic latch;
        logic scan;
        logic exec;
        logic shift;
        logic dec_count;
        logic load_res;
    } cmd_t;

    typedef struct packed {
        logic walk_done;
        logic need_shift;
    } stat_t;

endpackage

/* hw/rtl/blim_if.sv */
// Channel interfaces for requests, results and the capacity register write.
interface blim_req_if import blim_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [KEY_W-1:0]  key;

    modport source (output valid, output op, output key, input ready);
    modport sink   (input valid, input op, input key, output ready);
endinterface

interface blim_res_if import blim_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              ok;
    logic [KEY_W-1:0]  item;
    logic [STAT_W-1:0] match_count;
    logic [STAT_W-1:0] fill_level;
    logic              full_res;
    logic              empty_res;

    modport source (output valid, output ok, output item, output match_count,
                    output fill_level, output full_res, output empty_res, input ready);
    modport sink   (input valid, input ok, input item, input match_count,
                    input fill_level, input full_res, input empty_res, output ready);
endinterface

interface blim_cfg_if import blim_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/blim_ctrl.sv */
// Sequencing state machine for one list operation: scan, execute, compact, report.
module blim_ctrl import blim_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_SHIFT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.latch     = (state_reg == S_IDLE) && in_valid;
        cmd.scan      = (state_reg == S_SCAN);
        cmd.exec      = (state_reg == S_EXEC);
        cmd.shift     = (state_reg == S_SHIFT);
        cmd.dec_count = (state_reg == S_SHIFT) && stat.walk_done;
        // The result register is free, or its transaction completes this cycle.
        cmd.load_res  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (stat.walk_done)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = stat.need_shift ? S_SHIFT : S_DONE;
            end
            S_SHIFT:
            begin
                if (stat.walk_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_res)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

/* hw/rtl/blim_dp.sv */
// Datapath: slot memory, fill count, capacity register, scan counters and result register.
module blim_dp import blim_pkg::*; #(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int ID_BITS   = DEF_ID_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output stat_t             stat,
    input  logic [OP_W-1:0]   in_op,
    input  logic [KEY_W-1:0]  in_key,
    input  logic              cfg_we,
    input  logic [CAP_W-1:0]  cfg_data,
    output logic              res_ok,
    output logic [KEY_W-1:0]  res_item,
    output logic [STAT_W-1:0] res_match_count,
    output logic [STAT_W-1:0] res_fill_level,
    output logic              res_full,
    output logic              res_empty
);

    localparam int CNT_W = $clog2(MAX_SLOTS + 1);
    localparam int AW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SLOTS);

    logic [ID_BITS-1:0] mem [MAX_SLOTS];
    logic [ID_BITS-1:0] rdata_reg;

    logic [OP_W-1:0]    op_reg;
    logic [ID_BITS-1:0] key_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   rd_idx_reg;
    logic               pend_reg;
    logic [CNT_W-1:0]   pend_idx_reg;
    logic [CNT_W-1:0]   matches_reg;
    logic               found_reg;
    logic [CNT_W-1:0]   first_reg;
    logic [ID_BITS-1:0] head_reg;
    logic [ID_BITS-1:0] tail_reg;
    logic               exec_ok_reg;
    logic [ID_BITS-1:0] exec_item_reg;

    logic               res_ok_reg;
    logic [KEY_W-1:0]   res_item_reg;
    logic [STAT_W-1:0]  res_match_reg;
    logic [STAT_W-1:0]  res_fill_reg;
    logic               res_full_reg;
    logic               res_empty_reg;

    logic [CMP_W-1:0]   cap_ext;
    logic [CMP_W-1:0]   cap_eff;
    logic [CMP_W-1:0]   count_ext;
    logic               has_room;
    logic               is_full;
    logic               nonempty;
    logic               rd_more;
    logic               rd_en;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ID_BITS-1:0] wr_data;
    logic [CNT_W-1:0]   pend_prev;
    logic               do_append;
    logic               do_pop_new;

    logic               exec_ok;
    logic [ID_BITS-1:0] exec_item;
    logic               need_shift;
    logic [CNT_W-1:0]   shift_start;

    function automatic logic [STAT_W-1:0] sat_stat(input logic [CNT_W-1:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        return (w > CMP_W'(STAT_MAX)) ? STAT_MAX : STAT_W'(w);
    endfunction

    // Capacity above the slot count saturates at the slot count.
    assign cap_ext   = CMP_W'(cap_reg);
    assign cap_eff   = (cap_ext > CMP_W'(MAX_SLOTS)) ? CMP_W'(MAX_SLOTS) : cap_ext;
    assign count_ext = CMP_W'(count_reg);
    assign has_room  = count_ext < cap_eff;
    assign is_full   = count_ext >= cap_eff;
    assign nonempty  = (count_reg != '0);
    assign rd_more   = rd_idx_reg < count_reg;

    always_comb
    begin
        exec_ok     = 1'b0;
        exec_item   = '0;
        need_shift  = 1'b0;
        shift_start = '0;
        unique case (op_reg)
            OP_APPEND:
            begin
                exec_ok = has_room;
            end
            OP_REMOVE:
            begin
                exec_ok     = found_reg;
                need_shift  = found_reg;
                shift_start = first_reg;
            end
            OP_POP_OLD:
            begin
                exec_ok    = nonempty;
                exec_item  = nonempty ? head_reg : '0;
                need_shift = nonempty;
            end
            OP_POP_NEW:
            begin
                exec_ok   = nonempty;
                exec_item = nonempty ? tail_reg : '0;
            end
            OP_QUERY:
            begin
                exec_ok = found_reg;
            end
            default:
            begin
                exec_ok = 1'b0;
            end
        endcase
    end

    assign do_append  = cmd.exec && (op_reg == OP_APPEND) && has_room;
    assign do_pop_new = cmd.exec && (op_reg == OP_POP_NEW) && nonempty;

    // Compaction reads entry i+1 while the entry fetched in the previous cycle lands one place down.
    assign rd_en     = (cmd.scan || cmd.shift) && rd_more;
    assign pend_prev = pend_idx_reg - 1'b1;
    assign wr_en     = do_append || (cmd.shift && pend_reg);
    assign wr_addr   = cmd.shift ? pend_prev[AW-1:0] : count_reg[AW-1:0];
    assign wr_data   = cmd.shift ? rdata_reg : key_reg;

    assign stat.walk_done  = !rd_more && !pend_reg;
    assign stat.need_shift = need_shift;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[rd_idx_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            cap_reg    <= CAP_RESET;
            pend_reg   <= 1'b0;
            rd_idx_reg <= '0;
        end
        else
        begin
            if (cfg_we)
                cap_reg <= cfg_data;

            if (do_append)
                count_reg <= count_reg + 1'b1;
            else if (do_pop_new || cmd.dec_count)
                count_reg <= count_reg - 1'b1;

            pend_reg <= rd_en;

            if (cmd.latch)
                rd_idx_reg <= '0;
            else if (cmd.exec)
                rd_idx_reg <= shift_start + 1'b1;
            else if (rd_en)
                rd_idx_reg <= rd_idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg      <= in_op;
            key_reg     <= ID_BITS'(in_key);
            matches_reg <= '0;
            found_reg   <= 1'b0;
            first_reg   <= '0;
        end

        if (rd_en)
            pend_idx_reg <= rd_idx_reg;

        if (cmd.scan && pend_reg)
        begin
            if (rdata_reg == key_reg)
            begin
                matches_reg <= matches_reg + 1'b1;
                if (!found_reg)
                begin
                    found_reg <= 1'b1;
                    first_reg <= pend_idx_reg;
                end
            end
            if (pend_idx_reg == '0)
                head_reg <= rdata_reg;
            if (pend_idx_reg + 1'b1 == count_reg)
                tail_reg <= rdata_reg;
        end

        if (cmd.exec)
        begin
            exec_ok_reg   <= exec_ok;
            exec_item_reg <= exec_item;
        end

        if (cmd.load_res)
        begin
            res_ok_reg    <= exec_ok_reg;
            res_item_reg  <= KEY_W'(exec_item_reg);
            res_match_reg <= sat_stat(matches_reg);
            res_fill_reg  <= sat_stat(count_reg);
            res_full_reg  <= is_full;
            res_empty_reg <= !nonempty;
        end
    end

    assign res_ok          = res_ok_reg;
    assign res_item        = res_item_reg;
    assign res_match_count = res_match_reg;
    assign res_fill_level  = res_fill_reg;
    assign res_full        = res_full_reg;
    assign res_empty       = res_empty_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("fill count exceeds slot count");

    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_append |=> count_reg == $past(count_reg) + 1'b1)
        else $error("accepted append did not grow the list by one");

    a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dec_count |-> count_reg != '0)
        else $error("compaction finished on an empty list");

    a_matches_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |-> matches_reg <= count_reg)
        else $error("match count larger than fill count");
`endif

endmodule

/* hw/rtl/bounded_item_list_with_match_unit.sv */
// Top level of the bounded item list with associative match.
//
//  Channel  Direction  Payload                                                 Handshake
//  req      sink       op, key                                                 valid/ready
//  res      source     ok, item, match_count, fill_level, full_res, empty_res  valid/ready
//  cfg      sink       data (capacity)                                         valid/ready
//
// One operation at a time: every operation scans the slot memory, read one entry a cycle,
// and a remove or pop-oldest that takes an entry reads it again for the compaction.
// A new request is taken while a finished result still waits in the output register.
// Reset clears the fill count and sets capacity to its default; slot contents are not cleared.
// A stalled result channel holds the next result in the datapath until the register frees.
module bounded_item_list_with_match_unit import blim_pkg::*; #(
    parameter int MAX_SLOTS = DEF_MAX_SLOTS,
    parameter int ID_BITS   = DEF_ID_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    blim_req_if.sink     req,
    blim_res_if.source   res,
    blim_cfg_if.sink     cfg
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg.ready = 1'b1;

    blim_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (res.valid),
        .out_ready (res.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    blim_dp #(
        .MAX_SLOTS (MAX_SLOTS),
        .ID_BITS   (ID_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_op           (req.op),
        .in_key          (req.key),
        .cfg_we          (cfg.valid && cfg.ready),
        .cfg_data        (cfg.data),
        .res_ok          (res.ok),
        .res_item        (res.item),
        .res_match_count (res.match_count),
        .res_fill_level  (res.fill_level),
        .res_full        (res.full_res),
        .res_empty       (res.empty_res)
    );

endmodule
